// ----- design/crcdf_pkg.sv -----
// ----------------------------------------------------------------------------
// crcdf_pkg
// Shared types, codes and the bytewise CRC-8 update for the packet deframer.
// ----------------------------------------------------------------------------
package crcdf_pkg;

   // Default sizes of the deframer.
   localparam int SLOTS_DEF       = 8;
   localparam int MAX_PAYLOAD_DEF = 64;
   localparam int SOURCES_DEF     = 2;

   // Frame layout.
   localparam logic [7:0] START_BYTE   = 8'h55;
   localparam int         HEADER_BYTES = 3;

   // Result status codes.
   localparam logic [2:0] ST_IGNORED   = 3'd0;
   localparam logic [2:0] ST_TAKEN     = 3'd1;
   localparam logic [2:0] ST_COMPLETE  = 3'd2;
   localparam logic [2:0] ST_CRC_ERROR = 3'd3;
   localparam logic [2:0] ST_TOO_LONG  = 3'd4;

   // Configuration register indexes and reset values.
   localparam logic [1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_POLY    = 2'd1;
   localparam logic [1:0] CSR_REFLECT = 2'd2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd100;
   localparam logic [7:0]  POLY_RESET    = 8'h07;
   localparam logic        REFLECT_RESET = 1'b0;

   typedef struct packed {
      logic [15:0] timeout_ms;
      logic [7:0]  crc_poly;
      logic        crc_reflect;
   } cfg_type;

   typedef struct packed {
      logic [2:0] status;
      logic       frame_source;
      logic [2:0] frame_slot;
      logic [7:0] frame_type;
      logic [7:0] frame_length;
   } rsp_item_type;

   // One byte through the CRC-8 register, MSB-first with the polynomial or
   // LSB-first with the bit-reversed polynomial.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                              input logic [7:0] data,
                                              input logic [7:0] poly,
                                              input logic       reflect);
      logic [7:0] c;
      logic [7:0] rpoly;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         rpoly[i] = poly[7 - i];
      end
      for (int k = 0; k < 8; k++) begin
         if (reflect) begin
            c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
         end else begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
         end
      end
      return c;
   endfunction

endpackage

// ----- design/crcdf_req_if.sv -----
// ----------------------------------------------------------------------------
// crcdf_req_if
// Input byte channel: one received byte with its link and timestamp.
// ----------------------------------------------------------------------------
interface crcdf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_byte;
   logic        source;
   logic [31:0] now_ms;

   modport source_mp (output valid, output rx_byte, output source, output now_ms,
                      input ready);
   modport sink (input valid, input rx_byte, input source, input now_ms,
                 output ready);
endinterface

// ----- design/crcdf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// crcdf_rsp_if
// Result channel: the parse outcome for one received byte.
// ----------------------------------------------------------------------------
interface crcdf_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic       frame_source;
   logic [2:0] frame_slot;
   logic [7:0] frame_type;
   logic [7:0] frame_length;

   modport source (output valid, output status, output frame_source, output frame_slot,
                   output frame_type, output frame_length, input ready);
   modport sink (input valid, input status, input frame_source, input frame_slot,
                 input frame_type, input frame_length, output ready);
endinterface

// ----- design/crcdf_store.sv -----
// ----------------------------------------------------------------------------
// crcdf_store
// Frame ring memory: one row of slot bytes per source and slot.
// ----------------------------------------------------------------------------
module crcdf_store #(
   parameter int DEPTH  = 1088,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data
);
   logic [7:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end
endmodule

// ----- design/crcdf_parser.sv -----
// ----------------------------------------------------------------------------
// crcdf_parser
// Per-source frame parser: state tables, CRC update and result decode.
// ----------------------------------------------------------------------------
module crcdf_parser #(
   parameter int SLOTS       = crcdf_pkg::SLOTS_DEF,
   parameter int MAX_PAYLOAD = crcdf_pkg::MAX_PAYLOAD_DEF,
   parameter int SOURCES     = crcdf_pkg::SOURCES_DEF,
   parameter int ADDR_W      = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   input  logic                   source,
   input  logic [31:0]            now_ms,
   input  crcdf_pkg::cfg_type     cfg,
   output crcdf_pkg::rsp_item_type item,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [7:0]             wr_data
);
   import crcdf_pkg::*;

   localparam int SRC_W      = (SOURCES > 1) ? $clog2(SOURCES) : 1;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int SLOT_BYTES = MAX_PAYLOAD + 4;

   logic [8:0]        position_ff    [SOURCES];
   logic              started_ff     [SOURCES];
   logic [7:0]        frame_len_ff   [SOURCES];
   logic [7:0]        frame_type_ff  [SOURCES];
   logic [7:0]        crc_ff         [SOURCES];
   logic [31:0]       start_time_ff  [SOURCES];
   logic [SLOT_W-1:0] write_slot_ff  [SOURCES];

   logic [8:0]        position_in;
   logic              started_in;
   logic [7:0]        frame_len_in;
   logic [7:0]        frame_type_in;
   logic [7:0]        crc_in;
   logic [31:0]       start_time_in;
   logic [SLOT_W-1:0] write_slot_in;

   logic              src_ok;
   logic [SRC_W-1:0]  idx;
   logic [8:0]        pos;
   logic [7:0]        len;
   logic [7:0]        typ;
   logic [7:0]        crc;
   logic [SLOT_W-1:0] slot;
   logic              timed_out;
   logic [7:0]        crc_next;
   logic              store_hit;
   logic [8:0]        store_pos;

   assign src_ok = (32'(source) < SOURCES);
   assign idx    = src_ok ? SRC_W'(source) : '0;
   assign pos    = position_ff[idx];
   assign len    = frame_len_ff[idx];
   assign typ    = frame_type_ff[idx];
   assign crc    = crc_ff[idx];
   assign slot   = write_slot_ff[idx];

   assign timed_out = started_ff[idx] &&
                      ((now_ms - start_time_ff[idx]) > {16'd0, cfg.timeout_ms});

   // The start byte always seeds the CRC from zero; later bytes continue it.
   assign crc_next = crc8_update((started_ff[idx] && !timed_out) ? crc : 8'd0, rx_byte,
                                 cfg.crc_poly, cfg.crc_reflect);

   always_comb begin
      position_in   = pos;
      started_in    = started_ff[idx];
      frame_len_in  = len;
      frame_type_in = typ;
      crc_in        = crc;
      start_time_in = start_time_ff[idx];
      write_slot_in = slot;
      store_hit     = 1'b0;
      store_pos     = pos;
      item          = '0;
      item.status       = ST_IGNORED;
      item.frame_source = source;

      if (src_ok) begin
         if (timed_out) begin
            started_in    = 1'b0;
            position_in   = '0;
            frame_len_in  = '0;
            frame_type_in = '0;
            crc_in        = '0;
         end

         if (!started_ff[idx] || timed_out) begin
            if (rx_byte == START_BYTE) begin
               started_in    = 1'b1;
               start_time_in = now_ms;
               crc_in        = crc_next;
               position_in   = 9'd1;
               store_hit     = 1'b1;
               store_pos     = 9'd0;
               item.status   = ST_TAKEN;
            end
         end else if (pos == 9'd1) begin
            frame_type_in = rx_byte;
            crc_in        = crc_next;
            position_in   = 9'd2;
            store_hit     = 1'b1;
            item.status   = ST_TAKEN;
         end else if (pos == 9'd2) begin
            if (rx_byte > 8'(MAX_PAYLOAD)) begin
               item.status       = ST_TOO_LONG;
               item.frame_type   = typ;
               item.frame_length = rx_byte;
               started_in    = 1'b0;
               position_in   = '0;
               frame_len_in  = '0;
               frame_type_in = '0;
               crc_in        = '0;
            end else begin
               frame_len_in = rx_byte;
               crc_in       = crc_next;
               position_in  = 9'd3;
               store_hit    = 1'b1;
               item.status  = ST_TAKEN;
            end
         end else if (pos >= ({1'b0, len} + 9'(HEADER_BYTES))) begin
            // Checksum byte: compare against the running CRC and close the frame.
            item.frame_type   = typ;
            item.frame_length = len;
            if (crc == rx_byte) begin
               store_hit       = 1'b1;
               item.status     = ST_COMPLETE;
               item.frame_slot = 3'(slot);
               write_slot_in   = (32'(slot) == SLOTS - 1) ? '0 : slot + 1'b1;
            end else begin
               item.status = ST_CRC_ERROR;
            end
            started_in    = 1'b0;
            position_in   = '0;
            frame_len_in  = '0;
            frame_type_in = '0;
            crc_in        = '0;
         end else begin
            crc_in      = crc_next;
            position_in = pos + 9'd1;
            store_hit   = 1'b1;
            item.status = ST_TAKEN;
         end
      end
   end

   assign wr_en   = step && store_hit && (32'(store_pos) < SLOT_BYTES);
   assign wr_addr = ADDR_W'((int'(idx) * SLOTS + int'(slot)) * SLOT_BYTES + int'(store_pos));
   assign wr_data = rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SOURCES; s++) begin
            position_ff[s]   <= '0;
            started_ff[s]    <= 1'b0;
            frame_len_ff[s]  <= '0;
            frame_type_ff[s] <= '0;
            crc_ff[s]        <= '0;
            start_time_ff[s] <= '0;
            write_slot_ff[s] <= '0;
         end
      end else if (step && src_ok) begin
         position_ff[idx]   <= position_in;
         started_ff[idx]    <= started_in;
         frame_len_ff[idx]  <= frame_len_in;
         frame_type_ff[idx] <= frame_type_in;
         crc_ff[idx]        <= crc_in;
         start_time_ff[idx] <= start_time_in;
         write_slot_ff[idx] <= write_slot_in;
      end
   end
endmodule

// ----- design/crc8_packet_deframer_core.sv -----
// ----------------------------------------------------------------------------
// crc8_packet_deframer_core
// Start-byte / length / CRC-8 frame parser for several byte links.
// ----------------------------------------------------------------------------
// Every accepted byte produces exactly one result, in order. A byte is held in
// the input register, is parsed against its link's state and lands in the
// result register, from which its result is offered. One byte can be accepted
// every cycle while results are taken without a stall; the rate is set by the
// combinational state update of the per-link parser (timeout compare plus
// bytewise CRC-8). The input side keeps accepting while a result waits to be
// taken, until both stages are full. Frame bytes are written to a ring memory
// of SLOTS rows per link; its contents start undefined and are not cleared
// after reset. Configuration registers are to be written through the csr port
// only while idle; the block itself does not enforce this.
module crc8_packet_deframer_core #(
   parameter int SLOTS       = crcdf_pkg::SLOTS_DEF,
   parameter int MAX_PAYLOAD = crcdf_pkg::MAX_PAYLOAD_DEF,
   parameter int SOURCES     = crcdf_pkg::SOURCES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   crcdf_req_if.sink   req_ch,
   crcdf_rsp_if.source rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import crcdf_pkg::*;

   localparam int DEPTH  = SOURCES * SLOTS * (MAX_PAYLOAD + 4);
   localparam int ADDR_W = $clog2(DEPTH);

   cfg_type      cfg_ff;
   logic         in_valid_ff;
   logic [7:0]   in_byte_ff;
   logic         in_source_ff;
   logic [31:0]  in_now_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;

   rsp_item_type item;
   logic         out_free;
   logic         step;
   logic         req_fire;
   logic         wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]   wr_data;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign step         = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms  <= TIMEOUT_RESET;
         cfg_ff.crc_poly    <= POLY_RESET;
         cfg_ff.crc_reflect <= REFLECT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIMEOUT: cfg_ff.timeout_ms  <= csr_wdata;
            CSR_POLY:    cfg_ff.crc_poly    <= csr_wdata[7:0];
            CSR_REFLECT: cfg_ff.crc_reflect <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff   <= req_ch.rx_byte;
         in_source_ff <= req_ch.source;
         in_now_ff    <= req_ch.now_ms;
      end
      if (step) begin
         out_item_ff <= item;
      end
   end

   crcdf_parser #(
      .SLOTS       (SLOTS),
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .SOURCES     (SOURCES),
      .ADDR_W      (ADDR_W)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .source  (in_source_ff),
      .now_ms  (in_now_ff),
      .cfg     (cfg_ff),
      .item    (item),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   crcdf_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.status       = out_item_ff.status;
   assign rsp_ch.frame_source = out_item_ff.frame_source;
   assign rsp_ch.frame_slot   = out_item_ff.frame_slot;
   assign rsp_ch.frame_type   = out_item_ff.frame_type;
   assign rsp_ch.frame_length = out_item_ff.frame_length;
endmodule

// ----- design/crcdf_checker.sv -----
// ----------------------------------------------------------------------------
// crcdf_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
module crcdf_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [2:0] status,
   input  logic [2:0] frame_slot,
   input  logic [7:0] frame_type,
   input  logic [7:0] frame_length
);
   import crcdf_pkg::*;

   // A stalled result keeps its value until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(frame_slot)
         && $stable(frame_type) && $stable(frame_length))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (status <= ST_TOO_LONG))
      else $error("status code out of range");

   // Only a completed frame names a ring slot.
   a_slot_only_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != ST_COMPLETE) |-> (frame_slot == 3'd0))
      else $error("slot reported without a completed frame");

   a_header_only_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((status == ST_IGNORED) || (status == ST_TAKEN))
         |-> (frame_type == 8'd0) && (frame_length == 8'd0))
      else $error("frame header reported on a plain byte");
endmodule

bind crc8_packet_deframer_core crcdf_checker u_crcdf_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .status       (rsp_ch.status),
   .frame_slot   (rsp_ch.frame_slot),
   .frame_type   (rsp_ch.frame_type),
   .frame_length (rsp_ch.frame_length)
);

// ----- dv/crc8_packet_deframer_core_tb.sv -----
// ----------------------------------------------------------------------------
// crc8_packet_deframer_core_tb
// Self-checking bench for the two-link CRC-8 deframer. Byte streams built from
// good, corrupted, oversized, truncated and stale frames on both links are fed
// through the request channel. A per-link parser model inside the bench
// predicts the outcome of every byte, and each response is checked in order.
// ----------------------------------------------------------------------------
module crc8_packet_deframer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import crcdf_pkg::*;

   localparam int MAX_LEN     = MAX_PAYLOAD_DEF;
   localparam int HOLD_CYCLES = 80;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 70;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum {FK_GOOD, FK_BAD_CRC, FK_TOO_LONG, FK_CUT, FK_LATE, FK_NOISE} frame_kind_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        link;
      logic [31:0] stamp;
   } rx_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       late;
   } lane_byte_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   crcdf_req_if req_if();
   crcdf_rsp_if rsp_if();

   crc8_packet_deframer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register values as the block currently holds them.
   logic [15:0] cfg_timeout;
   logic [7:0]  cfg_poly;
   logic        cfg_reflect;

   // Parser state of each link.
   logic [8:0]  lane_pos[2];
   logic        lane_busy[2];
   logic [7:0]  lane_len[2];
   logic [7:0]  lane_type[2];
   logic [7:0]  lane_crc[2];
   logic [31:0] lane_t0[2];
   logic [2:0]  lane_slot[2];

   rx_item_type   rx_pending[$];
   rsp_item_type  parse_expected[$];
   lane_byte_type lane_q[2][$];
   logic [31:0]   clock_ms;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_asked    = 0;
   int hold_taken    = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int items_queued  = 0;
   int mismatches    = 0;
   int results_seen  = 0;
   int n_complete    = 0;
   int n_crc_err     = 0;
   int n_too_long    = 0;
   int n_ignored     = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] data);
      logic [7:0] c;
      logic [7:0] mirrored;
      c = crc ^ data;
      mirrored = {<<{cfg_poly}};
      repeat (8) begin
         if (cfg_reflect) begin
            c = {1'b0, c[7:1]} ^ (c[0] ? mirrored : 8'h00);
         end else begin
            c = {c[6:0], 1'b0} ^ (c[7] ? cfg_poly : 8'h00);
         end
      end
      return c;
   endfunction

   function automatic void lane_idle(logic s);
      lane_busy[s] = 1'b0;
      lane_pos[s]  = '0;
      lane_len[s]  = '0;
      lane_type[s] = '0;
      lane_crc[s]  = '0;
   endfunction

   // Advances one link's parser by one byte and returns the outcome.
   function automatic rsp_item_type parse_byte(logic [7:0] b, logic s, logic [31:0] now);
      rsp_item_type r;
      int p;
      r = '0;
      r.status = ST_IGNORED;
      r.frame_source = s;
      if (lane_busy[s] && (now - lane_t0[s]) > {16'd0, cfg_timeout}) begin
         lane_idle(s);
      end
      if (!lane_busy[s]) begin
         if (b == START_BYTE) begin
            lane_busy[s] = 1'b1;
            lane_t0[s]   = now;
            lane_crc[s]  = crc_byte(8'h00, b);
            lane_pos[s]  = 9'd1;
            r.status     = ST_TAKEN;
         end
      end else begin
         p = lane_pos[s];
         if (p == 1) begin
            lane_type[s] = b;
            lane_crc[s]  = crc_byte(lane_crc[s], b);
            lane_pos[s]  = 9'd2;
            r.status     = ST_TAKEN;
         end else if (p == 2) begin
            if (b > MAX_LEN) begin
               r.status       = ST_TOO_LONG;
               r.frame_type   = lane_type[s];
               r.frame_length = b;
               lane_idle(s);
            end else begin
               lane_len[s] = b;
               lane_crc[s] = crc_byte(lane_crc[s], b);
               lane_pos[s] = 9'd3;
               r.status    = ST_TAKEN;
            end
         end else if (p >= int'(lane_len[s]) + HEADER_BYTES) begin
            r.frame_type   = lane_type[s];
            r.frame_length = lane_len[s];
            if (lane_crc[s] == b) begin
               r.status      = ST_COMPLETE;
               r.frame_slot  = lane_slot[s];
               lane_slot[s]  = lane_slot[s] + 3'd1;
            end else begin
               r.status = ST_CRC_ERROR;
            end
            lane_idle(s);
         end else begin
            lane_crc[s] = crc_byte(lane_crc[s], b);
            lane_pos[s] = 9'(p + 1);
            r.status    = ST_TAKEN;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      $display("[%0t] mismatch in %s of result %0d: got 0x%0h, expected 0x%0h",
               $realtime, what, results_seen, got, want);
   endtask

   task automatic push_byte(logic [7:0] b, logic s, logic [31:0] dt);
      clock_ms = clock_ms + dt;
      rx_pending.push_back('{data: b, link: s, stamp: clock_ms});
      items_queued++;
   endtask

   // Directed frame with all bytes at the same timestamp; flip corrupts the CRC.
   task automatic push_frame(logic s, logic [7:0] typ, logic [7:0] len, logic [7:0] flip);
      logic [7:0] crc;
      logic [7:0] b;
      crc = crc_byte(8'h00, START_BYTE);
      push_byte(START_BYTE, s, 0);
      crc = crc_byte(crc, typ);
      push_byte(typ, s, 0);
      crc = crc_byte(crc, len);
      push_byte(len, s, 0);
      repeat (len) begin
         b = 8'($urandom);
         crc = crc_byte(crc, b);
         push_byte(b, s, 0);
      end
      push_byte(crc ^ flip, s, 0);
   endtask

   function automatic frame_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 66) return FK_GOOD;
      if (r < 74) return FK_BAD_CRC;
      if (r < 80) return FK_TOO_LONG;
      if (r < 86) return FK_CUT;
      if (r < 92) return FK_LATE;
      return FK_NOISE;
   endfunction

   function automatic logic [7:0] pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return 8'($urandom_range(0, 8));
      if (r < 95) return 8'($urandom_range(9, MAX_LEN - 1));
      return 8'(MAX_LEN);
   endfunction

   task automatic stage_frame(int s, frame_kind_type kind);
      logic [7:0] bytes[$];
      logic [7:0] typ;
      logic [7:0] len;
      logic [7:0] crc;
      int cut;
      int late_at;
      typ = 8'($urandom);
      len = pick_len();
      late_at = -1;
      if (kind == FK_TOO_LONG) begin
         bytes = {START_BYTE, typ, 8'($urandom_range(MAX_LEN + 1, 255))};
      end else if (kind == FK_NOISE) begin
         repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom));
      end else begin
         bytes = {START_BYTE, typ, len};
         repeat (len) bytes.push_back(8'($urandom));
         crc = 8'h00;
         foreach (bytes[i]) crc = crc_byte(crc, bytes[i]);
         if (kind == FK_BAD_CRC) begin
            crc = crc ^ (8'h01 << $urandom_range(0, 7));
         end
         bytes.push_back(crc);
         if (kind == FK_CUT) begin
            cut = $urandom_range(1, bytes.size() - 1);
            while (bytes.size() > cut) void'(bytes.pop_back());
         end else if (kind == FK_LATE) begin
            late_at = $urandom_range(1, bytes.size() - 1);
         end
      end
      foreach (bytes[i]) lane_q[s].push_back('{data: bytes[i], late: (i == late_at)});
   endtask

   // Interleaves the staged bytes of both links into the send queue. Normal
   // steps keep a frame well inside the timeout; a late byte jumps past it.
   task automatic flush_lanes();
      lane_byte_type lb;
      int s;
      while (lane_q[0].size() != 0 || lane_q[1].size() != 0) begin
         if (lane_q[0].size() == 0) s = 1;
         else if (lane_q[1].size() == 0) s = 0;
         else s = $urandom_range(0, 1);
         lb = lane_q[s].pop_front();
         if (lb.late) begin
            push_byte(lb.data, 1'(s), {16'd0, cfg_timeout} + 32'd1 + 32'($urandom_range(0, 7)));
         end else begin
            push_byte(lb.data, 1'(s), 32'($urandom_range(0, cfg_timeout / 256)));
         end
      end
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic drain();
      while (rx_pending.size() != 0 || parse_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(logic [15:0] tmo, logic [7:0] poly, logic refl,
                            idle_mode_type mode, bit squeeze, logic [31:0] start_ms);
      int goal;
      drain();
      write_reg(CSR_TIMEOUT, tmo);
      write_reg(CSR_POLY, {8'h00, poly});
      write_reg(CSR_REFLECT, {15'd0, refl});
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_timeout = tmo;
      cfg_poly    = poly;
      cfg_reflect = refl;
      @(negedge clock);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 61;
            stall_pct     = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct     = 61;
         end
         default: begin
            send_idle_pct = 25;
            stall_pct     = 25;
         end
      endcase
      clock_ms = start_ms;
      goal = items_queued + PHASE_ITEMS;
      while (items_queued < goal) begin
         for (int s = 0; s < 2; s++) begin
            if ($urandom_range(0, 3) != 0) stage_frame(s, pick_kind());
         end
         flush_lanes();
      end
      if (squeeze) hold_asked++;
   endtask

   // Request side: holds each byte until it is taken, predicts on each transfer.
   always @(posedge clock) begin : drive_bytes
      bit took;
      took = req_if.valid && req_if.ready;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (took) begin
            parse_expected.push_back(parse_byte(rx_pending[0].data, rx_pending[0].link,
                                                rx_pending[0].stamp));
            void'(rx_pending.pop_front());
         end
         if (!req_if.valid || took) begin
            if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_if.valid   <= 1'b1;
               req_if.rx_byte <= rx_pending[0].data;
               req_if.source  <= rx_pending[0].link;
               req_if.now_ms  <= rx_pending[0].stamp;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response side: random stalls, long hold-offs on request, in-order check.
   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_taken != hold_asked) begin
            hold_taken++;
            hold_left = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            case (rsp_if.status)
               ST_COMPLETE:  n_complete++;
               ST_CRC_ERROR: n_crc_err++;
               ST_TOO_LONG:  n_too_long++;
               ST_IGNORED:   n_ignored++;
               default: ;
            endcase
            if (parse_expected.size() == 0) begin
               report_mismatch("unexpected transfer, status", rsp_if.status, 0);
            end else begin
               want = parse_expected.pop_front();
               if (rsp_if.status !== want.status)
                  report_mismatch("status", rsp_if.status, want.status);
               if (rsp_if.frame_source !== want.frame_source)
                  report_mismatch("frame_source", rsp_if.frame_source, want.frame_source);
               if (rsp_if.frame_slot !== want.frame_slot)
                  report_mismatch("frame_slot", rsp_if.frame_slot, want.frame_slot);
               if (rsp_if.frame_type !== want.frame_type)
                  report_mismatch("frame_type", rsp_if.frame_type, want.frame_type);
               if (rsp_if.frame_length !== want.frame_length)
                  report_mismatch("frame_length", rsp_if.frame_length, want.frame_length);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                  quiet_cycles, parse_expected.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_TIMEOUT;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      req_if.source  = 1'b0;
      req_if.now_ms  = '0;
      rsp_if.ready   = 1'b0;
      cfg_timeout    = TIMEOUT_RESET;
      cfg_poly       = POLY_RESET;
      cfg_reflect    = REFLECT_RESET;
      for (int s = 0; s < 2; s++) begin
         lane_idle(1'(s));
         lane_t0[s]   = '0;
         lane_slot[s] = '0;
      end
      clock_ms = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed bytes under the reset settings.
      push_byte(8'hFF, 1'b1, 0);                   // idle link drops non-start bytes
      push_byte(8'h00, 1'b0, 0);
      push_frame(1'b0, 8'h00, 8'd0, 8'h00);        // empty payload
      push_frame(1'b1, 8'hFF, 8'd1, 8'h00);
      push_frame(1'b0, 8'hA5, 8'd1, 8'h80);        // checksum off in one bit
      push_byte(START_BYTE, 1'b1, 0);              // length one over the store
      push_byte(8'h3C, 1'b1, 0);
      push_byte(8'(MAX_LEN + 1), 1'b1, 0);
      push_byte(START_BYTE, 1'b0, 0);              // largest length byte
      push_byte(8'h11, 1'b0, 0);
      push_byte(8'hFF, 1'b0, 0);
      // Silence equal to the timeout keeps the frame; one more millisecond drops it.
      push_byte(START_BYTE, 1'b1, 5);
      push_byte(8'h22, 1'b1, 100);
      push_byte(8'h02, 1'b1, 1);
      // A timestamp that steps back looks like a huge gap and restarts the parse.
      push_byte(START_BYTE, 1'b0, 0);
      push_byte(START_BYTE, 1'b0, 32'hFFFF_FFFF);

      run_phase(16'hFFFF, 8'h31, 1'b1, IDLE_NONE, 1'b1, 32'hFFFF_FF00);
      run_phase(16'h0000, 8'hFF, 1'b0, IDLE_SENDER, 1'b0, clock_ms);
      run_phase(16'd300, 8'h00, 1'b1, IDLE_RECEIVER, 1'b0, clock_ms);
      run_phase(16'($urandom), 8'($urandom), 1'($urandom), IDLE_BOTH, 1'b0, clock_ms);
      run_phase(16'd1, 8'h9B, 1'b0, IDLE_NONE, 1'b1, clock_ms);
      drain();
      repeat (8) @(posedge clock);

      $display("checked %0d bytes across six register settings, all idling modes and %0d holds",
               results_seen, hold_asked);
      $display("frames good %0d, checksum errors %0d, oversize %0d, bytes ignored %0d",
               n_complete, n_crc_err, n_too_long, n_ignored);
      if (mismatches == 0 && parse_expected.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
